### src/cfft_pkg.sv
// ----------------------------------------------------------------------------
// cfft_pkg: shared types and constants of the cell fault flag tracker
// Fault kinds, command and lost-sensor codes, field widths and the
// controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfft_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 4;
    localparam int CELL_W   = 6;
    localparam int MEAS_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int ACTION_W = 2;
    localparam int LOST_W   = 8;
    localparam int LIMIT_W  = 8;

    localparam int DEFAULT_NUM_CELLS = 64;
    localparam int KIND_COUNT        = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd2;

    // Command codes; the unused code behaves as a query
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Fault kinds that take part in the side calculations
    localparam logic [KIND_W-1:0] KIND_CRIT_TEMP = 4'd2;
    localparam logic [KIND_W-1:0] KIND_TEMP_LOW  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_TEMP_HIGH = 4'd4;
    localparam logic [KIND_W-1:0] KIND_VOLT_LOW  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_VOLT_HIGH = 4'd8;

    // Lost-sensor action codes
    localparam logic [ACTION_W-1:0] LOST_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] LOST_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] LOST_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } cfft_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } cfft_cmd_t;

endpackage : cfft_pkg

`default_nettype wire

### src/cfft_in_if.sv
// ----------------------------------------------------------------------------
// cfft_in_if: request channel of the cell fault flag tracker
// Valid/ready channel carrying one fault command request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfft_in_if
    import cfft_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [KIND_W-1:0] fault_kind;
    logic [CELL_W-1:0] cell_index;
    logic [MEAS_W-1:0] measurement;

    modport source (
        output valid, command, fault_kind, cell_index, measurement,
        input  ready
    );

    modport sink (
        input  valid, command, fault_kind, cell_index, measurement,
        output ready
    );
endinterface : cfft_in_if

`default_nettype wire

### src/cfft_out_if.sv
// ----------------------------------------------------------------------------
// cfft_out_if: result channel of the cell fault flag tracker
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfft_out_if
    import cfft_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                raise_event;
    logic                clear_event;
    logic [CELL_W-1:0]   event_cell;
    logic [MEAS_W-1:0]   event_measurement;
    logic                fault_active;
    logic [COUNT_W-1:0]  active_count;
    logic                voltage_valid;
    logic                temperature_valid;
    logic [ACTION_W-1:0] lost_sensor_action;
    logic [LOST_W-1:0]   lost_sensor_count;

    modport source (
        output valid, raise_event, clear_event, event_cell, event_measurement,
               fault_active, active_count, voltage_valid, temperature_valid,
               lost_sensor_action, lost_sensor_count,
        input  ready
    );

    modport sink (
        input  valid, raise_event, clear_event, event_cell, event_measurement,
               fault_active, active_count, voltage_valid, temperature_valid,
               lost_sensor_action, lost_sensor_count,
        output ready
    );
endinterface : cfft_out_if

`default_nettype wire

### src/cfft_cfg_if.sv
// ----------------------------------------------------------------------------
// cfft_cfg_if: configuration write channel
// Valid/ready channel carrying the lost-sensor limit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfft_cfg_if
    import cfft_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface : cfft_cfg_if

`default_nettype wire

### src/cell_fault_flag_tracker.sv
// ----------------------------------------------------------------------------
// cell_fault_flag_tracker: per-cell fault flags with per-kind active counts
// Usage:
//   in_ch  - requests: command (query/set/clear), fault kind, cell, measurement.
//   out_ch - one result per request: raise/clear events, the cell's flag,
//            the kind's active count, cell validity and lost-sensor status.
//   cfg    - writes the lost-sensor limit; always ready, write only while
//            no request is in flight.
//   A request is captured when accepted; in the update step the flags,
//   counts and result register are written, and the result is then
//   presented. One request is in flight at a time: the controller runs
//   accept/update/present and takes a request only once the result is taken.
//   A stalled receiver holds the result steady in the output register and
//   in_ch.ready stays low until the result is taken.
//   Reset clears every flag and count, sets the limit to 2 and returns the
//   controller to idle, ready for a request.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_fault_flag_tracker
    import cfft_pkg::*;
#(
    parameter int NUM_CELLS = DEFAULT_NUM_CELLS
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfft_in_if.sink    in_ch,
    cfft_out_if.source out_ch,
    cfft_cfg_if.sink   cfg
);

    cfft_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Sequence requests
    cfft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Hold state and form results
    cfft_datapath #(
        .NUM_CELLS (NUM_CELLS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .in_command         (in_ch.command),
        .in_kind            (in_ch.fault_kind),
        .in_cell            (in_ch.cell_index),
        .in_meas            (in_ch.measurement),
        .cfg_write          (cfg.valid),
        .cfg_data           (cfg.data),
        .raise_event        (out_ch.raise_event),
        .clear_event        (out_ch.clear_event),
        .event_cell         (out_ch.event_cell),
        .event_measurement  (out_ch.event_measurement),
        .fault_active       (out_ch.fault_active),
        .active_count       (out_ch.active_count),
        .voltage_valid      (out_ch.voltage_valid),
        .temperature_valid  (out_ch.temperature_valid),
        .lost_sensor_action (out_ch.lost_sensor_action),
        .lost_sensor_count  (out_ch.lost_sensor_count)
    );

endmodule : cell_fault_flag_tracker

`default_nettype wire

### src/cfft_ctrl.sv
// ----------------------------------------------------------------------------
// cfft_ctrl: request sequencer
// Takes a request, runs the read-modify-write step, then presents the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfft_ctrl
    import cfft_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output cfft_cmd_t      cmd
);

    cfft_state_t state_reg;
    cfft_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule : cfft_ctrl

`default_nettype wire

### src/cfft_datapath.sv
// ----------------------------------------------------------------------------
// cfft_datapath: fault flag storage and result formation
// Holds the per-kind cell flags and counts, the limit register, the
// captured request and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfft_datapath
    import cfft_pkg::*;
#(
    parameter int NUM_CELLS = DEFAULT_NUM_CELLS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfft_cmd_t           cmd,
    input  wire logic [CMD_W-1:0]    in_command,
    input  wire logic [KIND_W-1:0]   in_kind,
    input  wire logic [CELL_W-1:0]   in_cell,
    input  wire logic [MEAS_W-1:0]   in_meas,
    input  wire logic                cfg_write,
    input  wire logic [LIMIT_W-1:0]  cfg_data,
    output logic                     raise_event,
    output logic                     clear_event,
    output logic [CELL_W-1:0]        event_cell,
    output logic [MEAS_W-1:0]        event_measurement,
    output logic                     fault_active,
    output logic [COUNT_W-1:0]       active_count,
    output logic                     voltage_valid,
    output logic                     temperature_valid,
    output logic [ACTION_W-1:0]      lost_sensor_action,
    output logic [LOST_W-1:0]        lost_sensor_count
);

    localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(NUM_CELLS);

    // Captured request
    logic [CMD_W-1:0]  cmd_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [MEAS_W-1:0] meas_reg;

    // Fault state and limit
    logic [NUM_CELLS-1:0] bits_reg   [KIND_COUNT];
    logic [COUNT_W-1:0]   counts_reg [KIND_COUNT];
    logic [LIMIT_W-1:0]   limit_reg;

    // Result register
    logic                raise_reg;
    logic                clear_reg;
    logic [CELL_W-1:0]   ecell_reg;
    logic [MEAS_W-1:0]   emeas_reg;
    logic                active_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                vvalid_reg;
    logic                tvalid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [LOST_W-1:0]   lost_reg;

    // Step logic
    logic                kind_ok;
    logic                cell_ok;
    logic [KIND_W-1:0]   kind_sel;
    logic [IDX_W-1:0]    cidx;
    logic                was;
    logic                do_set;
    logic                do_clr;
    logic                new_flag;
    logic [COUNT_W-1:0]  cur_count;
    logic [COUNT_W-1:0]  new_count;
    logic                tl_flag;
    logic                th_flag;
    logic                vl_flag;
    logic                vh_flag;
    logic [COUNT_W-1:0]  tl_count;
    logic [COUNT_W-1:0]  th_count;
    logic [LOST_W-1:0]   lost_sum;
    logic                temp_kind;
    logic [ACTION_W-1:0] action;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_command;
            kind_reg <= in_kind;
            cell_reg <= in_cell;
            meas_reg <= in_meas;
        end
    end

    // Decode and read the addressed flag
    always_comb
    begin
        kind_ok  = (kind_reg < KIND_W'(KIND_COUNT));
        cell_ok  = ({1'b0, cell_reg} < (CELL_W + 1)'(NUM_CELLS));
        kind_sel = kind_ok ? kind_reg : '0;
        cidx     = cell_reg[IDX_W-1:0];
        was      = cell_ok && bits_reg[kind_sel][cidx];
        do_set   = kind_ok && (cmd_reg == CMD_SET) && cell_ok && !was;
        do_clr   = kind_ok && (cmd_reg == CMD_CLEAR) && cell_ok && was;
        new_flag = do_set ? 1'b1 : (do_clr ? 1'b0 : was);
        cur_count = counts_reg[kind_sel];
        new_count = cur_count;
        if (do_set && (cur_count < COUNT_MAX))
        begin
            new_count = cur_count + COUNT_W'(1);
        end
        else if (do_clr && (cur_count != '0))
        begin
            new_count = cur_count - COUNT_W'(1);
        end
    end

    // Flags and counts of the range kinds after the operation
    always_comb
    begin
        tl_flag  = cell_ok && bits_reg[KIND_TEMP_LOW][cidx];
        th_flag  = cell_ok && bits_reg[KIND_TEMP_HIGH][cidx];
        vl_flag  = cell_ok && bits_reg[KIND_VOLT_LOW][cidx];
        vh_flag  = cell_ok && bits_reg[KIND_VOLT_HIGH][cidx];
        tl_count = counts_reg[KIND_TEMP_LOW];
        th_count = counts_reg[KIND_TEMP_HIGH];
        if (kind_ok && (kind_reg == KIND_TEMP_LOW))
        begin
            tl_flag  = new_flag;
            tl_count = new_count;
        end
        if (kind_ok && (kind_reg == KIND_TEMP_HIGH))
        begin
            th_flag  = new_flag;
            th_count = new_count;
        end
        if (kind_ok && (kind_reg == KIND_VOLT_LOW))
        begin
            vl_flag = new_flag;
        end
        if (kind_ok && (kind_reg == KIND_VOLT_HIGH))
        begin
            vh_flag = new_flag;
        end
        lost_sum  = LOST_W'(tl_count) + LOST_W'(th_count);
        temp_kind = (kind_reg == KIND_CRIT_TEMP) || (kind_reg == KIND_TEMP_LOW)
                    || (kind_reg == KIND_TEMP_HIGH);
        action    = LOST_NONE;
        if (kind_ok && (cmd_reg == CMD_SET) && temp_kind)
        begin
            action = (lost_sum > LOST_W'(limit_reg)) ? LOST_SET : LOST_CLEAR;
        end
    end

    // Update fault state and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KIND_COUNT; k++)
            begin
                bits_reg[k]   <= '0;
                counts_reg[k] <= '0;
            end
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.exec && (do_set || do_clr))
            begin
                bits_reg[kind_sel][cidx] <= new_flag;
                counts_reg[kind_sel]     <= new_count;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            raise_reg  <= do_set;
            clear_reg  <= do_clr && (new_count == '0);
            ecell_reg  <= cell_reg;
            emeas_reg  <= do_set ? meas_reg : '0;
            active_reg <= kind_ok && new_flag;
            count_reg  <= kind_ok ? new_count : '0;
            vvalid_reg <= !vl_flag && !vh_flag;
            tvalid_reg <= !tl_flag && !th_flag;
            action_reg <= action;
            lost_reg   <= lost_sum;
        end
    end

    assign raise_event        = raise_reg;
    assign clear_event        = clear_reg;
    assign event_cell         = ecell_reg;
    assign event_measurement  = emeas_reg;
    assign fault_active       = active_reg;
    assign active_count       = count_reg;
    assign voltage_valid      = vvalid_reg;
    assign temperature_valid  = tvalid_reg;
    assign lost_sensor_action = action_reg;
    assign lost_sensor_count  = lost_reg;

endmodule : cfft_datapath

`default_nettype wire

### tb/fault_tracker_checker.sv
// ----------------------------------------------------------------------------
// fault_tracker_checker: result predictor and comparator
// Watches the request, result and limit-write channels of the cell fault
// flag tracker. It keeps its own flag map, per-kind counts and limit, works
// out one expected result per accepted request, and compares each accepted
// result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_tracker_checker
    import cfft_pkg::*;
#(
    parameter int NUM_CELLS = DEFAULT_NUM_CELLS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cfft_in_if        in_ch,
    cfft_out_if       out_ch,
    cfft_cfg_if       cfg,
    output int        mismatch_count,
    output int        outstanding,
    output int        results_seen,
    output int        raise_seen,
    output int        clear_seen,
    output int        lost_set_seen
);

    typedef struct packed {
        logic                raise_event;
        logic                clear_event;
        logic [CELL_W-1:0]   event_cell;
        logic [MEAS_W-1:0]   event_measurement;
        logic                fault_active;
        logic [COUNT_W-1:0]  active_count;
        logic                voltage_valid;
        logic                temperature_valid;
        logic [ACTION_W-1:0] lost_sensor_action;
        logic [LOST_W-1:0]   lost_sensor_count;
    } fault_result_t;

    // Shadow state of the tracker
    logic [NUM_CELLS-1:0] flag_map [KIND_COUNT];
    logic [COUNT_W-1:0]   kind_tally [KIND_COUNT];
    logic [LIMIT_W-1:0]   sensor_limit;

    fault_result_t expected_results [$];

    // Cells past the array never hold a flag
    function automatic logic cell_flag(int kind, int cell_num);
        return (cell_num < NUM_CELLS) ? flag_map[kind][cell_num] : 1'b0;
    endfunction

    // Apply one request to the shadow state and return its result
    function automatic fault_result_t apply_fault_request(
        logic [CMD_W-1:0]  cmd,
        logic [KIND_W-1:0] kind,
        logic [CELL_W-1:0] cell_num,
        logic [MEAS_W-1:0] meas
    );
        fault_result_t res;
        logic          was_set;
        int            temp_sum;
        res = '0;
        res.event_cell = cell_num;
        if (kind < KIND_COUNT)
        begin
            was_set = cell_flag(kind, cell_num);
            if (cmd == CMD_SET)
            begin
                if (cell_num < NUM_CELLS)
                begin
                    flag_map[kind][cell_num] = 1'b1;
                    if (!was_set)
                    begin
                        if (kind_tally[kind] < NUM_CELLS)
                            kind_tally[kind] = kind_tally[kind] + 1'b1;
                        res.raise_event       = 1'b1;
                        res.event_measurement = meas;
                    end
                end
                // Lost-sensor check follows every temperature set, new or not
                if (kind == KIND_CRIT_TEMP || kind == KIND_TEMP_LOW ||
                    kind == KIND_TEMP_HIGH)
                begin
                    temp_sum = kind_tally[KIND_TEMP_LOW] + kind_tally[KIND_TEMP_HIGH];
                    res.lost_sensor_action = (temp_sum > sensor_limit) ? LOST_SET
                                                                       : LOST_CLEAR;
                end
            end
            else if (cmd == CMD_CLEAR)
            begin
                if (cell_num < NUM_CELLS && was_set)
                begin
                    flag_map[kind][cell_num] = 1'b0;
                    if (kind_tally[kind] > 0)
                        kind_tally[kind] = kind_tally[kind] - 1'b1;
                    if (kind_tally[kind] == 0)
                        res.clear_event = 1'b1;
                end
            end
            res.fault_active = cell_flag(kind, cell_num);
            res.active_count = kind_tally[kind];
        end
        temp_sum = kind_tally[KIND_TEMP_LOW] + kind_tally[KIND_TEMP_HIGH];
        res.lost_sensor_count = temp_sum[LOST_W-1:0];
        res.voltage_valid     = !cell_flag(KIND_VOLT_LOW, cell_num) &&
                                !cell_flag(KIND_VOLT_HIGH, cell_num);
        res.temperature_valid = !cell_flag(KIND_TEMP_LOW, cell_num) &&
                                !cell_flag(KIND_TEMP_HIGH, cell_num);
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want,
                                          logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     want, got);
            mismatch_count = mismatch_count + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fault_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < KIND_COUNT; k++)
            begin
                flag_map[k]   = '0;
                kind_tally[k] = '0;
            end
            sensor_limit = LIMIT_RESET;
            expected_results.delete();
            mismatch_count = 0;
            outstanding   <= 0;
            results_seen  <= 0;
            raise_seen    <= 0;
            clear_seen    <= 0;
            lost_set_seen <= 0;
        end
        else
        begin
            // Check a delivered result against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result for cell %0d arrived with none expected",
                             $time, out_ch.event_cell);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("raise_event", want.raise_event, out_ch.raise_event);
                    compare_field("clear_event", want.clear_event, out_ch.clear_event);
                    compare_field("event_cell", want.event_cell, out_ch.event_cell);
                    compare_field("event_measurement", want.event_measurement,
                                  out_ch.event_measurement);
                    compare_field("fault_active", want.fault_active,
                                  out_ch.fault_active);
                    compare_field("active_count", want.active_count,
                                  out_ch.active_count);
                    compare_field("voltage_valid", want.voltage_valid,
                                  out_ch.voltage_valid);
                    compare_field("temperature_valid", want.temperature_valid,
                                  out_ch.temperature_valid);
                    compare_field("lost_sensor_action", want.lost_sensor_action,
                                  out_ch.lost_sensor_action);
                    compare_field("lost_sensor_count", want.lost_sensor_count,
                                  out_ch.lost_sensor_count);
                    if (want.raise_event)
                        raise_seen <= raise_seen + 1;
                    if (want.clear_event)
                        clear_seen <= clear_seen + 1;
                    if (want.lost_sensor_action == LOST_SET)
                        lost_set_seen <= lost_set_seen + 1;
                end
            end

            // Predict the result of an accepted request
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(apply_fault_request(in_ch.command,
                    in_ch.fault_kind, in_ch.cell_index, in_ch.measurement));

            // Track limit writes
            if (cfg.valid && cfg.ready)
                sensor_limit = cfg.data;

            outstanding <= expected_results.size();
        end
    end

endmodule : fault_tracker_checker

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench top of the cell fault flag tracker
// Drives requests and lost-sensor limit writes with random gaps and result
// stalls, runs a directed sequence and then phases of windowed, wide and
// full-sweep random traffic, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import cfft_pkg::*;

    localparam int NUM_CELLS      = 64;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLDOFF   = 80;

    // Codes the package does not name
    localparam logic [CMD_W-1:0]   CMD_SPARE          = 2'd3;
    localparam logic [KIND_W-1:0]  KIND_OVERTEMP      = 4'd0;
    localparam logic [KIND_W-1:0]  KIND_HIGH_IMPEDANCE = 4'd9;
    localparam logic [KIND_W-1:0]  KIND_UNKNOWN_FIRST = 4'd10;
    localparam logic [KIND_W-1:0]  KIND_UNKNOWN_LAST  = 4'd15;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN          = 8'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX          = 8'hFF;
    localparam logic [MEAS_W-1:0]  MEAS_MAX           = 16'hFFFF;

    typedef enum {
        PHASE_WINDOW,
        PHASE_WIDE,
        PHASE_SWEEP
    } phase_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cfft_in_if  in_ch ();
    cfft_out_if out_ch ();
    cfft_cfg_if cfg_ch ();

    int mismatch_count;
    int outstanding;
    int results_seen;
    int raise_seen;
    int clear_seen;
    int lost_set_seen;

    int requests_sent = 0;
    int limit_writes  = 0;
    int idle_cycles   = 0;
    bit no_sender_gaps = 1'b0;
    int cell_order [NUM_CELLS];

    cell_fault_flag_tracker #(
        .NUM_CELLS(NUM_CELLS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg_ch)
    );

    fault_tracker_checker #(
        .NUM_CELLS(NUM_CELLS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg           (cfg_ch),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .raise_seen    (raise_seen),
        .clear_seen    (clear_seen),
        .lost_set_seen (lost_set_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request after a random gap (none while sender gaps are off) and hold it until accepted
    task automatic offer_request(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] kind,
                                 logic [CELL_W-1:0] cell_sel, logic [MEAS_W-1:0] meas);
        int gap;
        gap = no_sender_gaps ? 0 : int'($urandom_range(0, 10));
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.fault_kind  <= kind;
        in_ch.cell_index  <= cell_sel;
        in_ch.measurement <= meas;
        do
            @(posedge clk);
        while (!in_ch.ready);
        requests_sent = requests_sent + 1;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sensor_limit(logic [LIMIT_W-1:0] value);
        wait_results_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_writes = limit_writes + 1;
    endtask

    task automatic shuffle_cell_order();
        int j;
        int tmp;
        for (int i = 0; i < NUM_CELLS; i++)
            cell_order[i] = i;
        for (int i = NUM_CELLS - 1; i > 0; i--)
        begin
            j             = $urandom_range(0, i);
            tmp           = cell_order[i];
            cell_order[i] = cell_order[j];
            cell_order[j] = tmp;
        end
    endtask

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, quiet stretches and two long hold-offs
    initial
    begin
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (taken == 300 || taken == 1200)
                stall = LONG_HOLDOFF;
            else
                stall = quiet ? 0 : int'($urandom_range(0, 10));
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            taken = taken + 1;
        end
    end

    // Request and limit-write stimulus
    initial
    begin
        int                phase;
        int                phase_items;
        int                window_base;
        int                pick;
        phase_kind_t       mode;
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] kind;
        logic [CELL_W-1:0] cell_sel;
        logic [LIMIT_W-1:0] new_limit;

        in_ch.valid       <= 1'b0;
        in_ch.command     <= CMD_QUERY;
        in_ch.fault_kind  <= KIND_OVERTEMP;
        in_ch.cell_index  <= '0;
        in_ch.measurement <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence with the reset limit
        offer_request(CMD_SET, KIND_OVERTEMP, 6'd0, 16'd0);
        offer_request(CMD_SET, KIND_HIGH_IMPEDANCE, 6'd63, MEAS_MAX);
        offer_request(CMD_SET, KIND_HIGH_IMPEDANCE, 6'd63, 16'h1234);
        offer_request(CMD_QUERY, KIND_HIGH_IMPEDANCE, 6'd63, MEAS_MAX);
        offer_request(CMD_SPARE, KIND_HIGH_IMPEDANCE, 6'd63, MEAS_MAX);
        offer_request(CMD_CLEAR, KIND_OVERTEMP, 6'd0, 16'd5);
        offer_request(CMD_CLEAR, KIND_OVERTEMP, 6'd0, 16'd6);
        offer_request(CMD_SET, KIND_CRIT_TEMP, 6'd5, 16'h0F0F);
        offer_request(CMD_SET, KIND_TEMP_LOW, 6'd1, 16'h00FF);
        offer_request(CMD_SET, KIND_TEMP_LOW, 6'd2, 16'hFF00);
        offer_request(CMD_SET, KIND_TEMP_LOW, 6'd3, 16'h5555);
        offer_request(CMD_SET, KIND_TEMP_LOW, 6'd2, 16'hAAAA);
        offer_request(CMD_SET, KIND_TEMP_HIGH, 6'd1, 16'h8001);
        offer_request(CMD_SET, KIND_VOLT_LOW, 6'd10, 16'h7FFE);
        offer_request(CMD_SET, KIND_VOLT_HIGH, 6'd10, 16'h0001);
        offer_request(CMD_QUERY, KIND_VOLT_LOW, 6'd10, 16'd0);
        offer_request(CMD_SET, KIND_UNKNOWN_FIRST, 6'd1, MEAS_MAX);
        offer_request(CMD_CLEAR, KIND_UNKNOWN_LAST, 6'd1, MEAS_MAX);
        offer_request(CMD_CLEAR, KIND_VOLT_LOW, 6'd10, 16'd0);
        offer_request(CMD_CLEAR, KIND_TEMP_LOW, 6'd1, 16'd0);
        offer_request(CMD_CLEAR, KIND_TEMP_LOW, 6'd2, 16'd0);
        offer_request(CMD_CLEAR, KIND_TEMP_LOW, 6'd3, 16'd0);
        offer_request(CMD_CLEAR, KIND_TEMP_HIGH, 6'd1, 16'd0);
        offer_request(CMD_CLEAR, KIND_HIGH_IMPEDANCE, 6'd63, 16'd0);
        offer_request(CMD_CLEAR, KIND_CRIT_TEMP, 6'd5, 16'd0);

        // Random phases, each behind its own limit setting
        phase = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
                new_limit = LIMIT_MIN;
            else if (phase == 1)
                new_limit = LIMIT_MAX;
            else if ($urandom_range(0, 3) == 0)
                new_limit = LIMIT_W'($urandom_range(0, 255));
            else
                new_limit = LIMIT_W'($urandom_range(0, 6));
            write_sensor_limit(new_limit);

            no_sender_gaps = ($urandom_range(0, 3) == 0);
            case (phase % 4)
                2:       mode = PHASE_WIDE;
                3:       mode = PHASE_SWEEP;
                default: mode = PHASE_WINDOW;
            endcase
            // Make sure a full sweep runs early while the limit is at its top
            if (phase == 1)
                mode = PHASE_SWEEP;
            phase_items = $urandom_range(120, 200);

            case (mode)
                PHASE_WINDOW:
                begin
                    // Few cells so counts rise and fall back to zero
                    window_base = $urandom_range(0, NUM_CELLS - 4);
                    for (int i = 0; i < phase_items; i++)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 45)
                            cmd = CMD_SET;
                        else if (pick < 90)
                            cmd = CMD_CLEAR;
                        else if (pick < 95)
                            cmd = CMD_QUERY;
                        else
                            cmd = CMD_SPARE;
                        if ($urandom_range(0, 9) < 6)
                        begin
                            case ($urandom_range(0, 4))
                                0:       kind = KIND_CRIT_TEMP;
                                1:       kind = KIND_TEMP_LOW;
                                2:       kind = KIND_TEMP_HIGH;
                                3:       kind = KIND_VOLT_LOW;
                                default: kind = KIND_VOLT_HIGH;
                            endcase
                        end
                        else
                            kind = KIND_W'($urandom_range(0, KIND_COUNT - 1));
                        cell_sel = CELL_W'(window_base + int'($urandom_range(0, 3)));
                        offer_request(cmd, kind, cell_sel,
                                      MEAS_W'($urandom_range(0, 65535)));
                    end
                end
                PHASE_WIDE:
                begin
                    for (int i = 0; i < phase_items; i++)
                        offer_request(CMD_W'($urandom_range(0, 3)),
                                      KIND_W'($urandom_range(0, KIND_UNKNOWN_LAST)),
                                      CELL_W'($urandom_range(0, NUM_CELLS - 1)),
                                      MEAS_W'($urandom_range(0, 65535)));
                end
                PHASE_SWEEP:
                begin
                    // Fill both temperature-range kinds, then empty them
                    for (int pass = 0; pass < 4; pass++)
                    begin
                        kind = (pass % 2 == 0) ? KIND_TEMP_LOW : KIND_TEMP_HIGH;
                        cmd  = (pass < 2) ? CMD_SET : CMD_CLEAR;
                        shuffle_cell_order();
                        for (int i = 0; i < NUM_CELLS; i++)
                        begin
                            offer_request(cmd, kind, CELL_W'(cell_order[i]),
                                          MEAS_W'($urandom_range(0, 65535)));
                            if ($urandom_range(0, 7) == 0)
                                offer_request(CMD_SET, KIND_CRIT_TEMP,
                                              CELL_W'($urandom_range(0, NUM_CELLS - 1)),
                                              MEAS_W'($urandom_range(0, 65535)));
                        end
                    end
                end
                default: ;
            endcase
            phase = phase + 1;
        end

        // Finish: drain, settle and report
        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("Run covered %0d requests in %0d phases with %0d limit writes.",
                 requests_sent, phase, limit_writes);
        $display("Checked %0d results: %0d raises, %0d zero-count clears, %0d lost-sensor sets.",
                 results_seen, raise_seen, clear_seen, lost_set_seen);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb_top

`default_nettype wire

### filelist.f
src/cfft_pkg.sv
src/cfft_in_if.sv
src/cfft_out_if.sv
src/cfft_cfg_if.sv
src/cfft_ctrl.sv
src/cfft_datapath.sv
src/cell_fault_flag_tracker.sv
tb/fault_tracker_checker.sv
tb/tb_top.sv
